### design/tvr_pkg.sv
package tvr_pkg;

  localparam int CoordW  = 12;
  localparam int VoxW    = 8;
  localparam int SizeW   = 5;
  localparam int ScaleW  = 24;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;
  localparam int WgtBits = 16;
  localparam int WgtW    = WgtBits + 1;
  localparam int MapW    = CoordW + 1 + ScaleW;
  localparam int MacAW   = 40;
  localparam int MacBW   = WgtW;
  localparam int ProdW   = MacAW + MacBW;
  localparam int AccXW   = 24;
  localparam int AccYW   = 40;
  localparam int AccZW   = 56;

  localparam logic [WgtW-1:0] WgtOne = WgtW'(1) << WgtBits;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH   = 3'd0,
    CFG_HEIGHT  = 3'd1,
    CFG_WIDTH   = 3'd2,
    CFG_SCALE_Z = 3'd3,
    CFG_SCALE_Y = 3'd4,
    CFG_SCALE_X = 3'd5,
    CFG_MODE    = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    MODE_NEAREST = 1'b0,
    MODE_LINEAR  = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_LOAD,
    MAC_X,
    MAC_Y,
    MAC_Z
  } mac_op_e;

  typedef struct packed {
    mac_op_e            op;
    logic [MacAW-1:0]   a;
    logic [MacBW-1:0]   b;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_Z,
    ST_MAP_Y,
    ST_MAP_X,
    ST_MAP_D,
    ST_READ,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_DONE
  } state_e;

endpackage

### design/tvr_ram.sv
module tvr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                            wdata_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tvr_mac.sv
module tvr_mac (
  input  logic                            clk_i,
  input  tvr_pkg::mac_ctrl_t              ctrl_i,
  output logic [tvr_pkg::MapW-1:0]        prod_o,
  output logic [tvr_pkg::AccZW-1:0]       acc_o
);

  logic [tvr_pkg::MacAW-1:0] a_op;
  logic [tvr_pkg::ProdW-1:0] prod;
  logic [tvr_pkg::MapW-1:0]  prod_q;
  logic [tvr_pkg::AccXW-1:0] accx_q;
  logic [tvr_pkg::AccYW-1:0] accy_q;
  logic [tvr_pkg::AccZW-1:0] accz_q;

  // y and z steps fold the lower accumulator into the next one
  always_comb begin
    case (ctrl_i.op)
      tvr_pkg::MAC_Y: a_op = tvr_pkg::MacAW'(accx_q);
      tvr_pkg::MAC_Z: a_op = accy_q;
      default:        a_op = ctrl_i.a;
    endcase
  end

  assign prod = tvr_pkg::ProdW'(a_op) * tvr_pkg::ProdW'(ctrl_i.b);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      tvr_pkg::MAC_LOAD: begin
        prod_q <= prod[tvr_pkg::MapW-1:0];
        accx_q <= '0;
        accy_q <= '0;
        accz_q <= '0;
      end
      tvr_pkg::MAC_X: begin
        accx_q <= accx_q + prod[tvr_pkg::AccXW-1:0];
      end
      tvr_pkg::MAC_Y: begin
        accy_q <= accy_q + prod[tvr_pkg::AccYW-1:0];
        accx_q <= '0;
      end
      tvr_pkg::MAC_Z: begin
        accz_q <= accz_q + prod[tvr_pkg::AccZW-1:0];
        accy_q <= '0;
      end
      default: ;
    endcase
  end

  assign prod_o = prod_q;
  assign acc_o  = accz_q;

endmodule

### design/trilinear_volume_resampler.sv
// Trilinear volume resampler. Write items store one 8-bit voxel into the source volume when
// the coordinates lie inside it and return one result. Sample items run through a single
// multiply-accumulate unit: three axis mappings, then the eight corners are read from the
// single-port volume memory and folded separably (8 x-steps, 4 y-steps, 2 z-steps, 1 leading
// read), then rounding; an output stall holds the result back. The input is not ready while
// an item is in flight. Nearest mode uses the same path with unit weights.
module trilinear_volume_resampler #(
  parameter int MAX_DEPTH     = 16,
  parameter int MAX_HEIGHT    = 16,
  parameter int MAX_WIDTH     = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tvr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tvr_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [tvr_pkg::CoordW-1:0]    coord_z_i,
  input  logic [tvr_pkg::CoordW-1:0]    coord_y_i,
  input  logic [tvr_pkg::CoordW-1:0]    coord_x_i,
  input  logic [tvr_pkg::VoxW-1:0]      voxel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tvr_pkg::VoxW-1:0]      voxel_out_o,
  output logic                          is_sample_o
);

  localparam int MapW     = tvr_pkg::MapW;
  localparam int SizeW    = tvr_pkg::SizeW;
  localparam int CoordW   = tvr_pkg::CoordW;
  localparam int WgtBits  = tvr_pkg::WgtBits;
  localparam int WgtW     = tvr_pkg::WgtW;
  localparam int MacAW    = tvr_pkg::MacAW;
  localparam int MacBW    = tvr_pkg::MacBW;
  localparam int AccZW    = tvr_pkg::AccZW;
  localparam int VoxW     = tvr_pkg::VoxW;
  localparam int RndSh    = 3 * WgtBits;
  localparam int StoreDepth = MAX_DEPTH * MAX_HEIGHT * MAX_WIDTH;
  localparam int AddrW    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [MapW-1:0] Half     = MapW'(1) << FRACTION_BITS;
  localparam logic [MapW-1:0] FracMask = (MapW'(1) << (FRACTION_BITS + 1)) - MapW'(1);
  localparam logic [AccZW:0]  RndAdd   = (AccZW + 1)'(1) << (RndSh - 1);

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] r, input int mx);
    logic [SizeW-1:0] e;
    if (r == '0) begin
      e = SizeW'(1);
    end else if (int'(r) > mx) begin
      e = SizeW'(mx);
    end else begin
      e = r;
    end
    return e;
  endfunction

  // configuration
  logic [SizeW-1:0]           depth_q, height_q, width_q;
  logic [tvr_pkg::ScaleW-1:0] scale_z_q, scale_y_q, scale_x_q;
  tvr_pkg::mode_e             mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= SizeW'(16);
      height_q  <= SizeW'(16);
      width_q   <= SizeW'(16);
      scale_z_q <= tvr_pkg::ScaleW'(65536);
      scale_y_q <= tvr_pkg::ScaleW'(65536);
      scale_x_q <= tvr_pkg::ScaleW'(65536);
      mode_q    <= tvr_pkg::MODE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (tvr_pkg::cfg_idx_e'(cfg_index_i))
        tvr_pkg::CFG_DEPTH:   depth_q   <= cfg_data_i[SizeW-1:0];
        tvr_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i[SizeW-1:0];
        tvr_pkg::CFG_WIDTH:   width_q   <= cfg_data_i[SizeW-1:0];
        tvr_pkg::CFG_SCALE_Z: scale_z_q <= cfg_data_i;
        tvr_pkg::CFG_SCALE_Y: scale_y_q <= cfg_data_i;
        tvr_pkg::CFG_SCALE_X: scale_x_q <= cfg_data_i;
        tvr_pkg::CFG_MODE:    mode_q    <= tvr_pkg::mode_e'(cfg_data_i[0]);
        default: ;
      endcase
    end
  end

  logic [SizeW-1:0] eff_z, eff_y, eff_x;
  assign eff_z = eff_size(depth_q, MAX_DEPTH);
  assign eff_y = eff_size(height_q, MAX_HEIGHT);
  assign eff_x = eff_size(width_q, MAX_WIDTH);

  // control and item state
  tvr_pkg::state_e state_q, state_d;
  logic [2:0]      k_q, k_d;
  logic            out_valid_q;
  tvr_pkg::op_e    op_q;
  logic [CoordW-1:0] cz_q, cy_q, cx_q;
  logic [VoxW-1:0] vout_q;
  logic            smp_q;

  logic [SizeW-1:0]   zlo_q, zhi_q, ylo_q, yhi_q, xlo_q, xhi_q;
  logic [WgtBits-1:0] zw1_q, yw1_q, xw1_q;
  logic [WgtW-1:0]    zw0, yw0, xw0;

  assign zw0 = tvr_pkg::WgtOne - WgtW'(zw1_q);
  assign yw0 = tvr_pkg::WgtOne - WgtW'(yw1_q);
  assign xw0 = tvr_pkg::WgtOne - WgtW'(xw1_q);

  // shared multiplier
  tvr_pkg::mac_ctrl_t mac_ctrl;
  logic [MapW-1:0]    prod_q;
  logic [AccZW-1:0]   acc;

  tvr_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .prod_o (prod_q),
    .acc_o  (acc)
  );

  // volume memory
  logic            ram_en, ram_we;
  logic [AddrW-1:0] ram_addr, wr_addr, rd_addr;
  logic [VoxW-1:0] ram_rdata;
  logic [2:0]      rd_corner;
  logic            wr_inside;
  logic            accept;

  tvr_ram #(
    .Width (VoxW),
    .Depth (StoreDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (voxel_in_i),
    .rdata_o (ram_rdata)
  );

  assign accept    = in_valid_i && in_ready_o;
  assign wr_inside = (int'(coord_z_i) < MAX_DEPTH) && (int'(coord_y_i) < MAX_HEIGHT)
                     && (int'(coord_x_i) < MAX_WIDTH);
  assign wr_addr   = AddrW'((int'(coord_z_i) * MAX_HEIGHT + int'(coord_y_i)) * MAX_WIDTH
                            + int'(coord_x_i));
  assign rd_corner = (state_q == tvr_pkg::ST_READ) ? k_q : k_q + 3'd1;
  assign rd_addr   = AddrW'((int'(rd_corner[2] ? zhi_q : zlo_q) * MAX_HEIGHT
                             + int'(rd_corner[1] ? yhi_q : ylo_q)) * MAX_WIDTH
                            + int'(rd_corner[0] ? xhi_q : xlo_q));
  assign ram_addr  = ram_we ? wr_addr : rd_addr;

  // axis decode of the registered product
  logic [SizeW-1:0]          dec_m1, dec_lo, dec_hi;
  logic [MapW-1:0]           dec_t, dec_i;
  logic [MapW+WgtBits-1:0]   dec_fx;
  logic [WgtBits-1:0]        dec_w1;

  always_comb begin
    unique case (state_q)
      tvr_pkg::ST_MAP_Y: dec_m1 = eff_z - SizeW'(1);
      tvr_pkg::ST_MAP_X: dec_m1 = eff_y - SizeW'(1);
      default:           dec_m1 = eff_x - SizeW'(1);
    endcase
    dec_t  = prod_q - Half;
    dec_fx = {dec_t & FracMask, WgtBits'(0)} >> (FRACTION_BITS + 1);
    dec_lo = '0;
    dec_hi = '0;
    dec_w1 = '0;
    if (mode_q == tvr_pkg::MODE_NEAREST) begin
      dec_i = prod_q >> FRACTION_BITS;
      if (dec_i >= MapW'(dec_m1)) begin
        dec_lo = dec_m1;
      end else begin
        dec_lo = dec_i[SizeW-1:0];
      end
      dec_hi = dec_lo;
    end else begin
      dec_i = dec_t >> (FRACTION_BITS + 1);
      if (dec_m1 == '0 || prod_q < Half) begin
        dec_lo = '0;
        dec_hi = '0;
      end else if (dec_i >= MapW'(dec_m1)) begin
        dec_lo = dec_m1;
        dec_hi = dec_m1;
      end else begin
        dec_lo = dec_i[SizeW-1:0];
        dec_hi = dec_i[SizeW-1:0] + SizeW'(1);
        dec_w1 = dec_fx[WgtBits-1:0];
      end
    end
  end

  function automatic logic [MacBW-1:0] map_b(input logic [CoordW-1:0] o,
                                             input tvr_pkg::mode_e m);
    logic [MacBW-1:0] b;
    if (m == tvr_pkg::MODE_LINEAR) begin
      b = MacBW'({o, 1'b1});
    end else begin
      b = MacBW'(o);
    end
    return b;
  endfunction

  // sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    mac_ctrl.op = tvr_pkg::MAC_NONE;
    mac_ctrl.a  = '0;
    mac_ctrl.b  = '0;
    unique case (state_q)
      tvr_pkg::ST_IDLE: begin
        if (accept) begin
          k_d = '0;
          if (tvr_pkg::op_e'(operation_i) == tvr_pkg::OP_WRITE) begin
            ram_en  = wr_inside;
            ram_we  = wr_inside;
            state_d = tvr_pkg::ST_DONE;
          end else begin
            state_d = tvr_pkg::ST_MAP_Z;
          end
        end
      end
      tvr_pkg::ST_MAP_Z: begin
        mac_ctrl.op = tvr_pkg::MAC_LOAD;
        mac_ctrl.a  = MacAW'(scale_z_q);
        mac_ctrl.b  = map_b(cz_q, mode_q);
        state_d     = tvr_pkg::ST_MAP_Y;
      end
      tvr_pkg::ST_MAP_Y: begin
        mac_ctrl.op = tvr_pkg::MAC_LOAD;
        mac_ctrl.a  = MacAW'(scale_y_q);
        mac_ctrl.b  = map_b(cy_q, mode_q);
        state_d     = tvr_pkg::ST_MAP_X;
      end
      tvr_pkg::ST_MAP_X: begin
        mac_ctrl.op = tvr_pkg::MAC_LOAD;
        mac_ctrl.a  = MacAW'(scale_x_q);
        mac_ctrl.b  = map_b(cx_q, mode_q);
        state_d     = tvr_pkg::ST_MAP_D;
      end
      tvr_pkg::ST_MAP_D: begin
        state_d = tvr_pkg::ST_READ;
      end
      tvr_pkg::ST_READ: begin
        ram_en  = 1'b1;
        state_d = tvr_pkg::ST_MX;
      end
      tvr_pkg::ST_MX: begin
        mac_ctrl.op = tvr_pkg::MAC_X;
        mac_ctrl.a  = MacAW'(ram_rdata);
        mac_ctrl.b  = k_q[0] ? WgtW'(xw1_q) : xw0;
        if (k_q[0]) begin
          state_d = tvr_pkg::ST_MY;
        end else begin
          ram_en = 1'b1;
          k_d    = k_q + 3'd1;
        end
      end
      tvr_pkg::ST_MY: begin
        mac_ctrl.op = tvr_pkg::MAC_Y;
        mac_ctrl.b  = k_q[1] ? WgtW'(yw1_q) : yw0;
        if (k_q[1]) begin
          state_d = tvr_pkg::ST_MZ;
        end else begin
          ram_en  = 1'b1;
          k_d     = k_q + 3'd1;
          state_d = tvr_pkg::ST_MX;
        end
      end
      tvr_pkg::ST_MZ: begin
        mac_ctrl.op = tvr_pkg::MAC_Z;
        mac_ctrl.b  = k_q[2] ? WgtW'(zw1_q) : zw0;
        if (k_q[2]) begin
          state_d = tvr_pkg::ST_DONE;
        end else begin
          ram_en  = 1'b1;
          k_d     = k_q + 3'd1;
          state_d = tvr_pkg::ST_MX;
        end
      end
      tvr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = tvr_pkg::ST_IDLE;
        end
      end
      default: state_d = tvr_pkg::ST_IDLE;
    endcase
  end

  logic            load_out;
  logic [AccZW:0]  rnd_sum;
  logic [AccZW-RndSh:0] rnd;
  logic [VoxW-1:0] res;

  assign load_out = (state_q == tvr_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  assign rnd_sum  = {1'b0, acc} + RndAdd;
  assign rnd      = rnd_sum[AccZW:RndSh];
  assign res      = (op_q == tvr_pkg::OP_WRITE) ? '0 :
                    (rnd > (AccZW - RndSh + 1)'(255)) ? VoxW'(255) : rnd[VoxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tvr_pkg::ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= tvr_pkg::op_e'(operation_i);
      cz_q <= coord_z_i;
      cy_q <= coord_y_i;
      cx_q <= coord_x_i;
    end
    if (state_q == tvr_pkg::ST_MAP_Y) begin
      zlo_q <= dec_lo;
      zhi_q <= dec_hi;
      zw1_q <= dec_w1;
    end
    if (state_q == tvr_pkg::ST_MAP_X) begin
      ylo_q <= dec_lo;
      yhi_q <= dec_hi;
      yw1_q <= dec_w1;
    end
    if (state_q == tvr_pkg::ST_MAP_D) begin
      xlo_q <= dec_lo;
      xhi_q <= dec_hi;
      xw1_q <= dec_w1;
    end
    if (load_out) begin
      vout_q <= res;
      smp_q  <= (op_q == tvr_pkg::OP_SAMPLE);
    end
  end

  assign in_ready_o  = (state_q == tvr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign voxel_out_o = vout_q;
  assign is_sample_o = smp_q;

  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_sample_o |-> voxel_out_o == '0)
    else $error("write result carries nonzero voxel");

  a_z_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tvr_pkg::ST_MZ |-> k_q[1:0] == 2'b11)
    else $error("z fold before y pair complete");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != tvr_pkg::ST_IDLE)
    else $error("transfer did not start work");

endmodule
